[rtl/uniform_bspline_evaluator_core_macros.svh]
// Assertion macros shared by the uniform B-spline evaluator RTL.
`ifndef UNIFORM_BSPLINE_EVALUATOR_CORE_MACROS_SVH
`define UNIFORM_BSPLINE_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define UBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ubs assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define UBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ubs assertion failed");
`else
`define UBS_ASSERT_IMP(lbl, ante, cons)
`define UBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/ubs_pkg.sv]
// Types, constants and helper functions of the uniform B-spline evaluator.
package ubs_pkg;

	localparam int NUM_POINTS_DEF = 16;
	localparam int MAX_DEGREE_DEF = 3;

	localparam int TIME_W    = 32;
	localparam int VAL_W     = 24;
	localparam int IDX_W     = 4;
	localparam int DEG_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = 3;   // holds degrees and loop counters up to 7
	localparam int MUL_W     = 36;  // signed operand width of the shared multiplier
	localparam int PROD_W    = 2 * MUL_W;
	localparam int F_W       = 20;  // Q4.16 interpolation factors
	localparam int ACC_W     = 52;
	localparam int T_W       = 34;
	localparam int RECIP_W   = 35;
	localparam int RECIP_SH  = 34;
	localparam int BASIS_W   = 32;
	localparam int SUM_W     = 58;
	localparam int QDEPTH    = 2;
	localparam int QC_W      = 2;

	localparam logic [BASIS_W-1:0] ONE_Q30 = BASIS_W'(1) << 30;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEGREE       = 2'd0,
		CFG_INV_INTERVAL = 2'd1,
		CFG_START_TIME   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DEG_W-1:0]  degree;
		logic [TIME_W-1:0] inv_interval;
		logic [TIME_W-1:0] start_time;
	} cfg_t;

	typedef struct packed {
		logic                    op;
		logic                    in_range;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic [TIME_W-1:0]       qtime;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_MUL,
		ST_MAP_CAP,
		ST_TERM1,
		ST_TERM2,
		ST_NORM,
		ST_RECIP,
		ST_ROUND,
		ST_SUM_RD,
		ST_SUM_MUL,
		ST_SUM_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [QC_W-1:0] count;
	} front_stat_t;

	typedef struct packed {
		state_t state;
	} back_stat_t;

	// ceil(2^34 / k): the quotient from this reciprocal is exact or one too high.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] k);
		logic [RECIP_W-1:0] m;
		case (k)
			3'd1:    m = 35'd17179869184;
			3'd2:    m = 35'd8589934592;
			3'd3:    m = 35'd5726623062;
			3'd4:    m = 35'd4294967296;
			3'd5:    m = 35'd3435973837;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[rtl/ubs_ifs.sv]
// Handshake channel interfaces of the uniform B-spline evaluator.
interface ubs_in_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [ubs_pkg::IDX_W-1:0]        point_index;
	logic signed [ubs_pkg::VAL_W-1:0] point_value;
	logic [ubs_pkg::TIME_W-1:0]       query_time;
	modport source(output valid, op, point_index, point_value, query_time, input ready);
	modport sink(input valid, op, point_index, point_value, query_time, output ready);
endinterface

interface ubs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ubs_pkg::VAL_W-1:0] spline_value;
	modport source(output valid, spline_value, input ready);
	modport sink(input valid, spline_value, output ready);
endinterface

interface ubs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ubs_pkg::CFG_IDX_W-1:0] index;
	logic [ubs_pkg::TIME_W-1:0]    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/uniform_bspline_evaluator_core.sv]
// Top level of the uniform B-spline evaluator: configuration registers and the two halves.
// The block holds NUM_POINTS control values (Q8.16) and evaluates a uniform B-spline of
// the configured degree d (saturated to MAX_DEGREE) at a Q16.16 query time. A write
// request stores one control value and gives no result. An evaluate request gives one
// saturated Q8.16 result, worked out step by step on the single shared multiplier:
// every basis weight of the Cox-de Boor recursion takes two products, a rounding step
// and a reciprocal multiply in place of the division by the level, and every control
// value read from the table takes a read, a product and an accumulate. A two-entry
// queue in front lets requests be taken while the back end is busy, and a result
// register lets the next request start while a result waits to be taken.
// Control values read as zero until written; indices outside the table add nothing.
// Configuration writes must come while the block is idle.
`include "uniform_bspline_evaluator_core_macros.svh"

module uniform_bspline_evaluator_core #(
	parameter int NUM_POINTS = ubs_pkg::NUM_POINTS_DEF,
	parameter int MAX_DEGREE = ubs_pkg::MAX_DEGREE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ubs_in_if.sink     in_ch,
	ubs_out_if.source  out_ch,
	ubs_cfg_if.sink    cfg_ch
);
	ubs_pkg::cfg_t        cfg_q;
	ubs_pkg::item_t       q_item;
	logic                 q_valid, q_ready;
	ubs_pkg::front_stat_t fr_stat;
	ubs_pkg::back_stat_t  bk_stat;

	// The configuration channel never stalls; an unknown register index is dropped.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree       <= ubs_pkg::DEG_W'(3);
			cfg_q.inv_interval <= ubs_pkg::TIME_W'(65536);
			cfg_q.start_time   <= '0;
		end else if (cfg_ch.valid) begin
			case (ubs_pkg::cfg_idx_t'(cfg_ch.index))
				ubs_pkg::CFG_DEGREE:       cfg_q.degree <= cfg_ch.data[ubs_pkg::DEG_W-1:0];
				ubs_pkg::CFG_INV_INTERVAL: cfg_q.inv_interval <= cfg_ch.data;
				ubs_pkg::CFG_START_TIME:   cfg_q.start_time <= cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

	// The front end takes requests and keeps them in order for the back end.
	ubs_front #(.NUM_POINTS(NUM_POINTS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.stat    (fr_stat)
	);

	// The back end executes writes and evaluations one at a time, in request order.
	ubs_back #(.NUM_POINTS(NUM_POINTS), .MAX_DEGREE(MAX_DEGREE)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.out_ch  (out_ch),
		.stat    (bk_stat)
	);

	// The queue never holds more than its depth.
	`UBS_ASSERT_IMP(a_queue_bound, 1'b1, fr_stat.count <= ubs_pkg::QC_W'(ubs_pkg::QDEPTH))
	// Input ready is offered only when the queue has room.
	`UBS_ASSERT_IMP(a_ready_room, in_ch.ready, fr_stat.count < ubs_pkg::QC_W'(ubs_pkg::QDEPTH))
	// A new result appears only right after the back end finished an evaluation.
	`UBS_ASSERT_IMP(a_result_src, $rose(out_ch.valid), $past(bk_stat.state) == ubs_pkg::ST_DONE)
	// The back end does not leave idle while the queue is empty.
	`UBS_ASSERT_NXT(a_eval_start, bk_stat.state == ubs_pkg::ST_IDLE && !q_valid,
		bk_stat.state == ubs_pkg::ST_IDLE)
endmodule

[rtl/ubs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ubs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/ubs_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module ubs_front #(
	parameter int NUM_POINTS = ubs_pkg::NUM_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ubs_in_if.sink               in_ch,
	output ubs_pkg::item_t       q_item,
	output logic                 q_valid,
	input  logic                 q_ready,
	output ubs_pkg::front_stat_t stat
);
	ubs_pkg::item_t              ent_q [ubs_pkg::QDEPTH];
	logic                        wr_ptr_q, rd_ptr_q;
	logic [ubs_pkg::QC_W-1:0]    count_q;
	logic                        push, pop;
	ubs_pkg::item_t              new_item;

	assign in_ch.ready = (count_q != ubs_pkg::QC_W'(ubs_pkg::QDEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_valid && q_ready;
	assign q_item      = ent_q[rd_ptr_q];
	assign stat.count  = count_q;

	// A write to an index past the table is flagged here and dropped later.
	always_comb begin
		new_item.op       = in_ch.op;
		new_item.in_range = ({1'b0, in_ch.point_index} < (ubs_pkg::IDX_W + 1)'(NUM_POINTS))
			|| (NUM_POINTS > (1 << ubs_pkg::IDX_W));
		new_item.index    = in_ch.point_index;
		new_item.value    = in_ch.point_value;
		new_item.qtime    = in_ch.query_time;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[rtl/ubs_back.sv]
// Back end: control table, basis recursion on one shared multiplier, output register.
module ubs_back #(
	parameter int NUM_POINTS = ubs_pkg::NUM_POINTS_DEF,
	parameter int MAX_DEGREE = ubs_pkg::MAX_DEGREE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ubs_pkg::cfg_t       cfg,
	input  ubs_pkg::item_t      q_item,
	input  logic                q_valid,
	output logic                q_ready,
	ubs_out_if.source           out_ch,
	output ubs_pkg::back_stat_t stat
);
	localparam int AW   = $clog2(NUM_POINTS);
	localparam int BI_W = $clog2(MAX_DEGREE + 1);
	localparam int CW   = ubs_pkg::CNT_W;

	ubs_pkg::state_t state_q, state_d;

	logic [ubs_pkg::BASIS_W-1:0]        basis_q [MAX_DEGREE + 1];
	logic [NUM_POINTS-1:0]              vld_q;
	logic [CW-1:0]                      k_q, r_q, deg;
	logic [ubs_pkg::TIME_W-1:0]         qtime_q;
	logic signed [ubs_pkg::TIME_W-1:0]  s_q;
	logic [15:0]                        u_q;
	logic [ubs_pkg::ACC_W-1:0]          acc_q;
	logic [ubs_pkg::T_W-1:0]            t_q;
	logic signed [ubs_pkg::SUM_W-1:0]   sum_q;
	logic                               inr_q;
	logic signed [ubs_pkg::PROD_W-1:0]  prod_q;
	logic                               out_valid_q;
	logic signed [ubs_pkg::VAL_W-1:0]   out_val_q;

	logic signed [ubs_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [ubs_pkg::TIME_W-1:0]         diff;
	logic [CW-1:0]                      rm1, kp1r;
	logic [ubs_pkg::F_W-1:0]            f1, f2;
	logic [ubs_pkg::T_W-1:0]            t_d, q0, q_fix;
	logic [ubs_pkg::T_W+CW-1:0]         qk;
	logic signed [33:0]                 idx;
	logic                               idx_ok;
	logic [AW-1:0]                      raddr, waddr;
	logic                               we;
	logic [ubs_pkg::VAL_W-1:0]          rdata;
	logic signed [ubs_pkg::SUM_W-1:0]   rnd_full;
	logic signed [ubs_pkg::SUM_W-31:0]  rnd;
	logic signed [ubs_pkg::VAL_W-1:0]   sat;
	logic                               out_free;

	assign deg = (CW'(cfg.degree) > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : CW'(cfg.degree);
	assign rm1 = r_q - CW'(1);
	assign kp1r = k_q + CW'(1) - r_q;
	assign diff = qtime_q - cfg.start_time;
	assign f1 = ubs_pkg::F_W'(u_q) + (ubs_pkg::F_W'(r_q) << 16);
	assign f2 = (ubs_pkg::F_W'(kp1r) << 16) - ubs_pkg::F_W'(u_q);
	assign t_d = ubs_pkg::T_W'((ubs_pkg::ACC_W'(acc_q) + prod_q[ubs_pkg::ACC_W-1:0]
		+ (ubs_pkg::ACC_W'(k_q) << 15)) >> 16);
	assign q0 = prod_q[ubs_pkg::RECIP_SH+ubs_pkg::T_W-1:ubs_pkg::RECIP_SH];
	assign qk = (ubs_pkg::T_W + CW)'(q0) * (ubs_pkg::T_W + CW)'(k_q);
	assign q_fix = (qk > (ubs_pkg::T_W + CW)'(t_q)) ? q0 - 1'b1 : q0;
	assign idx = 34'(s_q) + 34'(deg) - 34'(r_q);
	assign idx_ok = (idx >= 34'sd0) && (idx < $signed(34'(NUM_POINTS)));
	assign raddr = idx[AW-1:0];
	assign waddr = AW'(q_item.index);
	assign rnd_full = (sum_q + (ubs_pkg::SUM_W'(1) <<< 29)) >>> 30;
	assign rnd = rnd_full[ubs_pkg::SUM_W-31:0];
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.spline_value = out_val_q;
	assign stat.state = state_q;

	always_comb begin
		if (rnd > 28'sd8388607) begin
			sat = 24'sh7FFFFF;
		end else if (rnd < -28'sd8388608) begin
			sat = 24'sh800000;
		end else begin
			sat = rnd[ubs_pkg::VAL_W-1:0];
		end
	end

	ubs_ram #(.WIDTH(ubs_pkg::VAL_W), .DEPTH(NUM_POINTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_item.value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state, queue pop and multiplier operand selection.
	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		we      = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			ubs_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_item.op == ubs_pkg::OP_EVAL) begin
						state_d = ubs_pkg::ST_MAP_MUL;
					end else begin
						we = q_item.in_range;
					end
				end
			end
			ubs_pkg::ST_MAP_MUL: begin
				mul_a = {{(ubs_pkg::MUL_W - ubs_pkg::TIME_W){diff[ubs_pkg::TIME_W-1]}}, diff};
				mul_b = {{(ubs_pkg::MUL_W - ubs_pkg::TIME_W){1'b0}}, cfg.inv_interval};
				state_d = ubs_pkg::ST_MAP_CAP;
			end
			ubs_pkg::ST_MAP_CAP: begin
				state_d = (deg == '0) ? ubs_pkg::ST_SUM_RD : ubs_pkg::ST_TERM1;
			end
			ubs_pkg::ST_TERM1: begin
				if (r_q < k_q) begin
					mul_a = ubs_pkg::MUL_W'(f1);
					mul_b = ubs_pkg::MUL_W'(basis_q[r_q[BI_W-1:0]]);
				end
				state_d = ubs_pkg::ST_TERM2;
			end
			ubs_pkg::ST_TERM2: begin
				if (r_q != '0) begin
					mul_a = ubs_pkg::MUL_W'(f2);
					mul_b = ubs_pkg::MUL_W'(basis_q[rm1[BI_W-1:0]]);
				end
				state_d = ubs_pkg::ST_NORM;
			end
			ubs_pkg::ST_NORM: begin
				state_d = ubs_pkg::ST_RECIP;
			end
			ubs_pkg::ST_RECIP: begin
				mul_a = ubs_pkg::MUL_W'(t_q);
				mul_b = ubs_pkg::MUL_W'(ubs_pkg::recip(k_q));
				state_d = ubs_pkg::ST_ROUND;
			end
			ubs_pkg::ST_ROUND: begin
				if (r_q != '0) begin
					state_d = ubs_pkg::ST_TERM1;
				end else if (k_q == deg) begin
					state_d = ubs_pkg::ST_SUM_RD;
				end else begin
					state_d = ubs_pkg::ST_TERM1;
				end
			end
			ubs_pkg::ST_SUM_RD: begin
				state_d = ubs_pkg::ST_SUM_MUL;
			end
			ubs_pkg::ST_SUM_MUL: begin
				if (inr_q) begin
					mul_a = {{(ubs_pkg::MUL_W - ubs_pkg::VAL_W){rdata[ubs_pkg::VAL_W-1]}}, rdata};
				end
				mul_b = ubs_pkg::MUL_W'(basis_q[r_q[BI_W-1:0]]);
				state_d = ubs_pkg::ST_SUM_ACC;
			end
			ubs_pkg::ST_SUM_ACC: begin
				state_d = (r_q == deg) ? ubs_pkg::ST_DONE : ubs_pkg::ST_SUM_RD;
			end
			ubs_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ubs_pkg::ST_IDLE;
				end
			end
			default: state_d = ubs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ubs_pkg::ST_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (state_q == ubs_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ubs_pkg::ST_IDLE: begin
				qtime_q <= q_item.qtime;
			end
			ubs_pkg::ST_MAP_CAP: begin
				s_q        <= prod_q[63:32];
				u_q        <= prod_q[31:16];
				basis_q[0] <= ubs_pkg::ONE_Q30;
				k_q        <= CW'(1);
				r_q        <= (deg == '0) ? '0 : CW'(1);
				sum_q      <= '0;
			end
			ubs_pkg::ST_TERM2: begin
				acc_q <= prod_q[ubs_pkg::ACC_W-1:0];
			end
			ubs_pkg::ST_NORM: begin
				t_q <= t_d;
			end
			ubs_pkg::ST_ROUND: begin
				basis_q[r_q[BI_W-1:0]] <= q_fix[ubs_pkg::BASIS_W-1:0];
				if (r_q != '0) begin
					r_q <= rm1;
				end else if (k_q == deg) begin
					r_q <= '0;
				end else begin
					k_q <= k_q + CW'(1);
					r_q <= k_q + CW'(1);
				end
			end
			ubs_pkg::ST_SUM_RD: begin
				inr_q <= idx_ok && vld_q[raddr];
			end
			ubs_pkg::ST_SUM_ACC: begin
				sum_q <= sum_q + prod_q[ubs_pkg::SUM_W-1:0];
				r_q   <= r_q + CW'(1);
			end
			ubs_pkg::ST_DONE: begin
				if (out_free) begin
					out_val_q <= sat;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[test/tb_top.sv]
// Self-checking testbench of the uniform B-spline evaluator with a scoreboard class.
module tb_top;

	localparam int          PERIOD_HI   = 6;
	localparam int          PERIOD_LO   = 6;
	localparam int          TABLE_SIZE  = 16;
	localparam int          N_PHASES    = 8;
	localparam int          PHASE_ITEMS = 205;
	// Idle wait after the last result so that trailing queued writes settle.
	localparam int          DRAIN_WAIT  = 160;
	localparam longint      CYCLE_LIMIT = 1500000;
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;

	// The scoreboard keeps its own copy of the configuration and of the control
	// table, predicts each evaluation at the moment the request is taken and
	// holds the predicted values in order until the block hands them back.
	class spline_scoreboard;
		logic [ubs_pkg::DEG_W-1:0]        degree;
		logic [ubs_pkg::TIME_W-1:0]       inv_interval;
		logic [ubs_pkg::TIME_W-1:0]       start_time;
		logic signed [ubs_pkg::VAL_W-1:0] points[TABLE_SIZE];
		logic signed [ubs_pkg::VAL_W-1:0] expected_values[$];
		int                               errors;
		int                               evals_checked;
		int                               writes_seen;

		function new();
			degree       = 2'd3;
			inv_interval = 32'd65536;
			start_time   = '0;
			foreach (points[i])
				points[i] = '0;
			errors        = 0;
			evals_checked = 0;
			writes_seen   = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] data);
			if (idx == ubs_pkg::CFG_DEGREE)
				degree = data[ubs_pkg::DEG_W-1:0];
			else if (idx == ubs_pkg::CFG_INV_INTERVAL)
				inv_interval = data;
			else if (idx == ubs_pkg::CFG_START_TIME)
				start_time = data;
		endfunction

		// Cox-de Boor evaluation in Q.30 weights with exact intermediate products.
		function logic signed [ubs_pkg::VAL_W-1:0] spline_at(logic [ubs_pkg::TIME_W-1:0] qt);
			int unsigned                d;
			longint                     diff, prod, s, sum, res, idx;
			longint unsigned            u, acc, den;
			longint unsigned            bas[4];
			longint unsigned            prv[4];
			logic [ubs_pkg::TIME_W-1:0] delta;
			d = degree;
			if (d > 3)
				d = 3;
			delta = qt - start_time;
			diff  = longint'($signed(delta));
			prod  = diff * longint'(inv_interval);
			s     = prod >>> 32;
			u     = prod[31:16];
			bas[0] = 64'd1 << 30;
			for (int k = 1; k <= d; k++) begin
				for (int r = 0; r < k; r++)
					prv[r] = bas[r];
				den = longint'(k) << 16;
				for (int r = 0; r <= k; r++) begin
					acc = 0;
					if (r < k)
						acc += (u + (longint'(r) << 16)) * prv[r];
					if (r >= 1)
						acc += ((longint'(k + 1 - r) << 16) - u) * prv[r-1];
					bas[r] = (acc + (den >> 1)) / den;
				end
			end
			sum = 0;
			for (int r = 0; r <= d; r++) begin
				idx = s + longint'(d) - longint'(r);
				if (idx >= 0 && idx < TABLE_SIZE)
					sum += longint'(points[idx]) * longint'(bas[r]);
			end
			res = (sum + 64'sd536870912) >>> 30;
			if (res > 64'sd8388607)
				res = 64'sd8388607;
			if (res < -64'sd8388608)
				res = -64'sd8388608;
			return res[ubs_pkg::VAL_W-1:0];
		endfunction

		function void note_request(logic op, logic [ubs_pkg::IDX_W-1:0] idx,
				logic signed [ubs_pkg::VAL_W-1:0] val, logic [ubs_pkg::TIME_W-1:0] qt);
			if (op == ubs_pkg::OP_WRITE) begin
				points[idx] = val;
				writes_seen++;
			end else begin
				expected_values.push_back(spline_at(qt));
			end
		endfunction

		function void check_result(logic signed [ubs_pkg::VAL_W-1:0] got);
			logic signed [ubs_pkg::VAL_W-1:0] want;
			if (expected_values.size() == 0) begin
				$error("unexpected result spline_value=%0d", got);
				errors++;
				return;
			end
			want = expected_values.pop_front();
			evals_checked++;
			if (got !== want) begin
				$error("spline_value mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	int     send_idle_pct;
	int     recv_stall_pct;
	longint cycles = 0;

	ubs_in_if  in_ch();
	ubs_out_if out_ch();
	ubs_cfg_if cfg_ch();

	spline_scoreboard sb;

	uniform_bspline_evaluator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		clk = 1'b1;
		#PERIOD_HI;
		clk = 1'b0;
		#PERIOD_LO;
	end

	// Timeout guard: a hung block must not keep the run alive.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: check every accepted result and stall ready at random.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.spline_value);
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sends one request. Valid stays high from one request to the next unless
	// the sender decides to idle, so there is only one assignment per edge.
	task automatic send_request(logic op, logic [ubs_pkg::IDX_W-1:0] idx,
			logic signed [ubs_pkg::VAL_W-1:0] val, logic [ubs_pkg::TIME_W-1:0] qt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.op          <= op;
		in_ch.point_index <= idx;
		in_ch.point_value <= val;
		in_ch.query_time  <= qt;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_request(op, idx, val, qt);
	endtask

	// Valid stays high across back-to-back writes; the caller drops it afterwards.
	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.set_register(idx, data);
	endtask

	// Waits for all predicted results, then lets trailing writes settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Picks a query time whose knot coordinate mostly lands on or near the table.
	function automatic logic [ubs_pkg::TIME_W-1:0] aimed_time();
		longint x_target, diff;
		x_target = longint'($urandom_range(0, 22 << 16)) - (longint'(3) << 16);
		if (sb.inv_interval == 0)
			diff = longint'($signed($urandom));
		else
			diff = (x_target <<< 16) / longint'(sb.inv_interval);
		if (diff > 64'sd2147483647)
			diff = 64'sd2147483647;
		if (diff < -64'sd2147483648)
			diff = -64'sd2147483648;
		return sb.start_time + diff[31:0];
	endfunction

	task automatic random_requests(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				send_request(ubs_pkg::OP_WRITE, ubs_pkg::IDX_W'($urandom),
					ubs_pkg::VAL_W'($urandom), $urandom);
			else if (pick < 85)
				send_request(ubs_pkg::OP_EVAL, ubs_pkg::IDX_W'($urandom),
					ubs_pkg::VAL_W'($urandom), aimed_time());
			else
				send_request(ubs_pkg::OP_EVAL, ubs_pkg::IDX_W'($urandom),
					ubs_pkg::VAL_W'($urandom), $urandom);
		end
	endtask

	task automatic directed_requests();
		// Extreme control values at both ends of the table.
		send_request(ubs_pkg::OP_WRITE, 4'd0, 24'sh800000, 32'hFFFFFFFF);
		send_request(ubs_pkg::OP_WRITE, 4'd15, 24'sh7FFFFF, 32'h0);
		send_request(ubs_pkg::OP_WRITE, 4'd1, 24'sh7FFFFF, 32'h0);
		send_request(ubs_pkg::OP_WRITE, 4'd2, 24'sh7FFFFF, 32'h0);
		send_request(ubs_pkg::OP_WRITE, 4'd3, 24'sh7FFFFF, 32'h0);
		send_request(ubs_pkg::OP_WRITE, 4'd14, 24'sh800000, 32'h0);
		// Evaluation at the start, inside, at the top end and past the table.
		send_request(ubs_pkg::OP_EVAL, 4'hF, 24'sh7FFFFF, 32'h0);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'sh800000, 32'h0002_8000);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h0003_0000);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h000D_FFFF);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h000F_0000);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h0020_0000);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h7FFF_FFFF);
		// Queries before the start give a negative coordinate.
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'hFFFF_FFFF);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'hFFFE_8000);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h8000_0000);
		// Overwrite and read back straight away.
		send_request(ubs_pkg::OP_WRITE, 4'd1, 24'sh000001, 32'hFFFFFFFF);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h0001_0000);
		send_request(ubs_pkg::OP_WRITE, 4'd0, 24'h0, 32'h0);
		send_request(ubs_pkg::OP_EVAL, 4'h0, 24'h0, 32'h0000_FFFF);
	endtask

	initial begin
		logic [ubs_pkg::DEG_W-1:0] degrees[N_PHASES] =
			'{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1};
		logic [31:0]               invs[N_PHASES];
		logic [31:0]               starts[N_PHASES];
		sb     = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		invs   = '{32'd65536, 32'hFFFFFFFF, 32'd0, 32'd32768, 32'd131072,
			32'd0, 32'd65536, 32'd0};
		starts = '{32'd0, 32'hFFFFFFFF, 32'd0, 32'h8000_0000, 32'd0,
			32'd0, 32'hFFFF_0000, 32'd0};
		invs[5]   = $urandom;
		invs[7]   = $urandom_range(20000, 300000);
		starts[4] = $urandom;
		starts[7] = $urandom;

		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.op          <= ubs_pkg::OP_WRITE;
		in_ch.point_index <= '0;
		in_ch.point_value <= '0;
		in_ch.query_time  <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= ubs_pkg::CFG_DEGREE;
		cfg_ch.data       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			// Phase 0 runs on the reset configuration; the others rewrite it.
			if (p > 0) begin
				write_register(ubs_pkg::CFG_DEGREE, {30'($urandom), degrees[p]});
				write_register(ubs_pkg::CFG_INV_INTERVAL, invs[p]);
				write_register(ubs_pkg::CFG_START_TIME, starts[p]);
				if (p == 1)
					write_register(CFG_UNUSED, $urandom);
				cfg_ch.valid <= 1'b0;
			end
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			if (p == 0)
				directed_requests();
			random_requests(PHASE_ITEMS);
			drain();
		end

		$display("covered %0d configuration phases, %0d control writes, %0d evaluations",
			N_PHASES, sb.writes_seen, sb.evals_checked);
		$display("degrees 0 to 3, zero and full-scale intervals, idle and stall mixes");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
